// File: sv/qpt_pkg.sv
// ----------------------------------------------------------------------------
// qpt_pkg
// Shared types and constants of the quaternion point transform unit.
// ----------------------------------------------------------------------------
package qpt_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SENSOR_W = 8;
  localparam int unsigned IDX_W    = 3;
  // cycles from a register write until the rotation matrix is current
  localparam int unsigned COEF_LAT = 3;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [IDX_W-1:0] {
    REG_QUAT_X  = 3'd0,
    REG_QUAT_Y  = 3'd1,
    REG_QUAT_Z  = 3'd2,
    REG_QUAT_W  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } reg_idx_e;

  // rot[row][col] in Q2.30, shift in coordinate format
  typedef struct packed {
    word_t [2:0][2:0] rot;
    word_t [2:0]      shift;
  } xform_t;

  typedef struct packed {
    logic [WORD_W-1:0]   speed;
    logic [WORD_W-1:0]   distance;
    logic [WORD_W-1:0]   bearing;
    logic [WORD_W-1:0]   tilt;
    logic [SENSOR_W-1:0] sensor;
  } attr_t;

endpackage

// File: sv/qpt_coef.sv
// ----------------------------------------------------------------------------
// qpt_coef
// Configuration registers and the three-stage pipeline that turns the
// quaternion into the rotation matrix.
// ----------------------------------------------------------------------------
module qpt_coef import qpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  output xform_t           xform_o,
  output logic             busy_o
);

  localparam word_t QOne    = 32'sh4000_0000;
  localparam word_t QNegOne = 32'shC000_0000;
  localparam logic signed [63:0] OneQ60 = 64'sh1000_0000_0000_0000;

  function automatic logic signed [61:0] mul62(word_t a, word_t b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:0];
  endfunction

  function automatic word_t sat34(logic [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return word_t'(v[31:0]);
    end
    return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic word_t coef_diag(logic signed [62:0] s);
    logic signed [63:0] d;
    d = OneQ60 - (64'(s) <<< 1);
    return sat34(d[63:30]);
  endfunction

  function automatic word_t coef_off(logic signed [62:0] s);
    logic signed [63:0] d;
    d = 64'(s) <<< 1;
    return sat34(d[63:30]);
  endfunction

  function automatic word_t clamp_q(word_t v);
    if (v > QOne) begin
      return QOne;
    end
    if (v < QNegOne) begin
      return QNegOne;
    end
    return v;
  endfunction

  word_t quat_q [4];
  word_t shift_q [3];
  logic [1:0] wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0]  <= '0;
      quat_q[1]  <= '0;
      quat_q[2]  <= '0;
      quat_q[3]  <= QOne;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUAT_X:  quat_q[0]  <= word_t'(cfg_wdata_i);
        REG_QUAT_Y:  quat_q[1]  <= word_t'(cfg_wdata_i);
        REG_QUAT_Z:  quat_q[2]  <= word_t'(cfg_wdata_i);
        REG_QUAT_W:  quat_q[3]  <= word_t'(cfg_wdata_i);
        REG_SHIFT_X: shift_q[0] <= word_t'(cfg_wdata_i);
        REG_SHIFT_Y: shift_q[1] <= word_t'(cfg_wdata_i);
        REG_SHIFT_Z: shift_q[2] <= word_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    wait_d = wait_q;
    if (cfg_we_i) begin
      wait_d = 2'(COEF_LAT);
    end else if (wait_q != '0) begin
      wait_d = wait_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= 2'(COEF_LAT);
    end else begin
      wait_q <= wait_d;
    end
  end

  assign busy_o = (wait_q != '0);

  // stage 1: clamped components x, y, z, w
  word_t cq_q [4];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      cq_q[i] <= clamp_q(quat_q[i]);
    end
  end

  // stage 2: component products, Q2.60
  logic signed [61:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  always_ff @(posedge clk_i) begin
    xx_q <= mul62(cq_q[0], cq_q[0]);
    yy_q <= mul62(cq_q[1], cq_q[1]);
    zz_q <= mul62(cq_q[2], cq_q[2]);
    xy_q <= mul62(cq_q[0], cq_q[1]);
    xz_q <= mul62(cq_q[0], cq_q[2]);
    yz_q <= mul62(cq_q[1], cq_q[2]);
    xw_q <= mul62(cq_q[0], cq_q[3]);
    yw_q <= mul62(cq_q[1], cq_q[3]);
    zw_q <= mul62(cq_q[2], cq_q[3]);
  end

  // stage 3: matrix coefficients
  word_t rot_q [3][3];
  always_ff @(posedge clk_i) begin
    rot_q[0][0] <= coef_diag(63'(yy_q) + 63'(zz_q));
    rot_q[0][1] <= coef_off(63'(xy_q) - 63'(zw_q));
    rot_q[0][2] <= coef_off(63'(xz_q) + 63'(yw_q));
    rot_q[1][0] <= coef_off(63'(xy_q) + 63'(zw_q));
    rot_q[1][1] <= coef_diag(63'(xx_q) + 63'(zz_q));
    rot_q[1][2] <= coef_off(63'(yz_q) - 63'(xw_q));
    rot_q[2][0] <= coef_off(63'(xz_q) - 63'(yw_q));
    rot_q[2][1] <= coef_off(63'(yz_q) + 63'(xw_q));
    rot_q[2][2] <= coef_diag(63'(xx_q) + 63'(yy_q));
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        xform_o.rot[r][c] = rot_q[r][c];
      end
      xform_o.shift[r] = shift_q[r];
    end
  end

endmodule

// File: sv/qpt_datapath.sv
// ----------------------------------------------------------------------------
// qpt_datapath
// Three-stage point pipeline: products, row sums, translate and saturate.
// ----------------------------------------------------------------------------
module qpt_datapath import qpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  word_t [2:0] pos_i,
  input  attr_t       attr_i,
  input  xform_t      xform_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output word_t [2:0] out_pos_o,
  output attr_t       out_attr_o,
  output logic        clipped_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // stage 1: nine products
  logic signed [63:0] prod_q [3][3];
  attr_t a1_q, a2_q, a3_q;
  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(xform_i.rot[r][c]) * $signed(pos_i[c]);
        end
      end
      a1_q <= attr_i;
    end
  end

  // stage 2: floor of row sum over 2^30
  logic signed [35:0] row_q [3];
  logic signed [65:0] sum [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 66'(prod_q[r][0]) + 66'(prod_q[r][1]) + 66'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        row_q[r] <= sum[r][65:30];
      end
      a2_q <= a1_q;
    end
  end

  // stage 3: translate and saturate
  logic signed [36:0] tot [3];
  word_t res_d [3];
  logic [2:0] ovf;
  word_t res_q [3];
  logic clip_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tot[r] = 37'(row_q[r]) + 37'($signed(xform_i.shift[r]));
      ovf[r] = !(tot[r][36:31] == 6'b000000 || tot[r][36:31] == 6'b111111);
      if (ovf[r]) begin
        res_d[r] = tot[r][36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        res_d[r] = word_t'(tot[r][31:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        res_q[r] <= res_d[r];
      end
      clip_q <= |ovf;
      a3_q   <= a2_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      out_pos_o[r] = res_q[r];
    end
  end

  assign out_valid_o = v3_q;
  assign out_attr_o  = a3_q;
  assign clipped_o   = clip_q;

endmodule

// File: sv/quaternion_point_transform_unit.sv
// ----------------------------------------------------------------------------
// quaternion_point_transform_unit
// Rigid 3-D transform of radar points by a configured quaternion and shift.
// ----------------------------------------------------------------------------
// One point is taken per clock while the input is not stalled; each point
// passes the three point stages (products, row sums, translate/saturate).
// The rotation matrix is rebuilt from the quaternion registers in a separate
// three-stage pipeline; after a register write, and after reset, the input
// stalls while it settles. Coordinates and shift share one fixed-point format;
// quaternion parts are Q2.30 and are clamped to +-1.0.
module quaternion_point_transform_unit import qpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]      radial_speed_i,
  input  logic [31:0]      distance_i,
  input  logic [31:0]      bearing_i,
  input  logic [31:0]      tilt_i,
  input  logic [7:0]       sensor_id_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [31:0]      out_speed_o,
  output logic [31:0]      out_distance_o,
  output logic [31:0]      out_bearing_o,
  output logic [31:0]      out_tilt_o,
  output logic [7:0]       out_sensor_o,
  output logic             clipped_o
);

  xform_t      xform;
  logic        coef_busy;
  logic        dp_ready;
  word_t [2:0] pos_in;
  word_t [2:0] pos_out;
  attr_t       attr_in;
  attr_t       attr_out;

  qpt_coef u_coef (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .xform_o (xform),
    .busy_o  (coef_busy)
  );

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  assign attr_in.speed    = radial_speed_i;
  assign attr_in.distance = distance_i;
  assign attr_in.bearing  = bearing_i;
  assign attr_in.tilt     = tilt_i;
  assign attr_in.sensor   = sensor_id_i;

  qpt_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_valid_i && !coef_busy),
    .pos_i       (pos_in),
    .attr_i      (attr_in),
    .xform_i     (xform),
    .in_ready_o  (dp_ready),
    .out_valid_o,
    .out_stall_i,
    .out_pos_o   (pos_out),
    .out_attr_o  (attr_out),
    .clipped_o
  );

  assign in_stall_o = !dp_ready || coef_busy;

  assign out_x_o        = pos_out[0];
  assign out_y_o        = pos_out[1];
  assign out_z_o        = pos_out[2];
  assign out_speed_o    = attr_out.speed;
  assign out_distance_o = attr_out.distance;
  assign out_bearing_o  = attr_out.bearing;
  assign out_tilt_o     = attr_out.tilt;
  assign out_sensor_o   = attr_out.sensor;

`ifndef SYNTHESIS
  a_cfg_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input not stalled after register write");

  a_request_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i) |=> out_valid_o)
    else $error("request did not reach output in three cycles");

  a_clip_means_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (out_x_o == 32'sh7FFF_FFFF || out_x_o == 32'sh8000_0000 ||
       out_y_o == 32'sh7FFF_FFFF || out_y_o == 32'sh8000_0000 ||
       out_z_o == 32'sh7FFF_FFFF || out_z_o == 32'sh8000_0000))
    else $error("clip flag set without a saturated coordinate");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of quaternion_point_transform_unit.
// A scoreboard class predicts each transformed point from its own copy of the
// quaternion and shift registers and checks every result field in order.
// Directed phases cover identity, clamped and non-unit quaternions,
// saturation and ignored register writes. Random phases follow, with random
// gaps and stalls on both sides, a long output hold-off and an input pause.
// ----------------------------------------------------------------------------
module tb import qpt_pkg::*;;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned N_RANDOM    = 950;
  localparam int unsigned N_PHASES    = 10;
  localparam int unsigned LONG_HOLD   = 300;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam word_t W_MAX   = 32'sh7FFF_FFFF;
  localparam word_t W_MIN   = 32'sh8000_0000;
  localparam word_t Q_UNIT  = 32'sh4000_0000;
  localparam word_t Q_SIN45 = 32'sd759250125;

  typedef logic signed [127:0] wide_t;

  localparam wide_t ONE_Q60 = wide_t'(1) <<< 60;

  typedef struct packed {
    word_t qx, qy, qz, qw, tx, ty, tz;
  } xf_cfg_t;

  typedef struct packed {
    word_t [2:0] pos;
    attr_t       attr;
  } point_t;

  typedef struct packed {
    word_t [2:0] pos;
    attr_t       attr;
    logic        clip;
  } result_t;

  class xform_scoreboard;
    xf_cfg_t regs;
    result_t due_q[$];
    int      errors;

    function new();
      errors = 0;
      regs   = '{qx: '0, qy: '0, qz: '0, qw: Q_UNIT, tx: '0, ty: '0, tz: '0};
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, word_t data);
      case (idx)
        REG_QUAT_X:  regs.qx = data;
        REG_QUAT_Y:  regs.qy = data;
        REG_QUAT_Z:  regs.qz = data;
        REG_QUAT_W:  regs.qw = data;
        REG_SHIFT_X: regs.tx = data;
        REG_SHIFT_Y: regs.ty = data;
        REG_SHIFT_Z: regs.tz = data;
        default: ;
      endcase
    endfunction

    function wide_t clamp_unit(word_t v);
      wide_t w;
      w = wide_t'(v);
      if (w > wide_t'(Q_UNIT)) return wide_t'(Q_UNIT);
      if (w < -wide_t'(Q_UNIT)) return -wide_t'(Q_UNIT);
      return w;
    endfunction

    function wide_t sat_wide(wide_t v);
      if (v > wide_t'(W_MAX)) return wide_t'(W_MAX);
      if (v < wide_t'(W_MIN)) return wide_t'(W_MIN);
      return v;
    endfunction

    function wide_t coef_diag(wide_t s);
      return sat_wide((ONE_Q60 - 2 * s) >>> 30);
    endfunction

    function wide_t coef_off(wide_t s);
      return sat_wide((2 * s) >>> 30);
    endfunction

    function result_t predict_point(point_t p);
      wide_t   qx, qy, qz, qw, acc, lim;
      wide_t   m [3][3];
      wide_t   c [3];
      wide_t   t [3];
      result_t r;
      bit      hit;
      qx = clamp_unit(regs.qx);
      qy = clamp_unit(regs.qy);
      qz = clamp_unit(regs.qz);
      qw = clamp_unit(regs.qw);
      m[0][0] = coef_diag(qy * qy + qz * qz);
      m[0][1] = coef_off(qx * qy - qz * qw);
      m[0][2] = coef_off(qx * qz + qy * qw);
      m[1][0] = coef_off(qx * qy + qz * qw);
      m[1][1] = coef_diag(qx * qx + qz * qz);
      m[1][2] = coef_off(qy * qz - qx * qw);
      m[2][0] = coef_off(qx * qz - qy * qw);
      m[2][1] = coef_off(qy * qz + qx * qw);
      m[2][2] = coef_diag(qx * qx + qy * qy);
      t[0] = wide_t'(regs.tx);
      t[1] = wide_t'(regs.ty);
      t[2] = wide_t'(regs.tz);
      for (int i = 0; i < 3; i++) c[i] = wide_t'($signed(p.pos[i]));
      hit = 1'b0;
      for (int k = 0; k < 3; k++) begin
        acc = ((m[k][0] * c[0] + m[k][1] * c[1] + m[k][2] * c[2]) >>> 30) + t[k];
        lim = sat_wide(acc);
        if (lim != acc) hit = 1'b1;
        r.pos[k] = lim[31:0];
      end
      r.attr = p.attr;
      r.clip = hit;
      return r;
    endfunction

    function void note_point(point_t p);
      due_q.insert(due_q.size(), predict_point(p));
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        $error("result with no pending request");
        errors++;
        return;
      end
      want = due_q.pop_front();
      cmp_field("out_x", want.pos[0], got.pos[0]);
      cmp_field("out_y", want.pos[1], got.pos[1]);
      cmp_field("out_z", want.pos[2], got.pos[2]);
      cmp_field("out_speed", want.attr.speed, got.attr.speed);
      cmp_field("out_distance", want.attr.distance, got.attr.distance);
      cmp_field("out_bearing", want.attr.bearing, got.attr.bearing);
      cmp_field("out_tilt", want.attr.tilt, got.attr.tilt);
      cmp_field("out_sensor", want.attr.sensor, got.attr.sensor);
      cmp_field("clipped", want.clip, got.clip);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [31:0]      cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic signed [31:0] pos_x_i;
  logic signed [31:0] pos_y_i;
  logic signed [31:0] pos_z_i;
  logic [31:0]      radial_speed_i;
  logic [31:0]      distance_i;
  logic [31:0]      bearing_i;
  logic [31:0]      tilt_i;
  logic [7:0]       sensor_id_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic [31:0]      out_speed_o;
  logic [31:0]      out_distance_o;
  logic [31:0]      out_bearing_o;
  logic [31:0]      out_tilt_o;
  logic [7:0]       out_sensor_o;
  logic             clipped_o;

  xform_scoreboard sb;
  bit              idle_on;
  bit              hold_req;
  int unsigned     quiet_cnt;

  quaternion_point_transform_unit i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic attr_t random_attr();
    attr_t a;
    a.speed    = $urandom;
    a.distance = $urandom;
    a.bearing  = $urandom;
    a.tilt     = $urandom;
    a.sensor   = $urandom_range(0, 255);
    return a;
  endfunction

  function automatic point_t mk_point(word_t x, word_t y, word_t z, attr_t a);
    point_t p;
    p.pos[0] = x;
    p.pos[1] = y;
    p.pos[2] = z;
    p.attr   = a;
    return p;
  endfunction

  function automatic word_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return {{8{r[23]}}, r[23:0]};
      6, 7, 8: return r;
      default: begin
        case ($urandom_range(0, 3))
          0: return W_MAX;
          1: return W_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic word_t rand_shift();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return {{11{r[20]}}, r[20:0]};
      7, 8: return r;
      default: return r[0] ? W_MAX : W_MIN;
    endcase
  endfunction

  function automatic point_t random_point();
    return mk_point(rand_coord(), rand_coord(), rand_coord(), random_attr());
  endfunction

  function automatic xf_cfg_t random_xform();
    xf_cfg_t c;
    real     v [4];
    real     n;
    int      kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      do begin
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
          v[i] = (real'($urandom_range(0, 2000000)) - 1.0e6) / 1.0e6;
          n += v[i] * v[i];
        end
      end while (n < 0.01);
      n = $sqrt(n);
      c.qx = $rtoi(v[0] / n * 1073741824.0);
      c.qy = $rtoi(v[1] / n * 1073741824.0);
      c.qz = $rtoi(v[2] / n * 1073741824.0);
      c.qw = $rtoi(v[3] / n * 1073741824.0);
    end else if (kind < 8) begin
      // non-unit, still inside +-1.0
      c.qx = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      c.qy = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      c.qz = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      c.qw = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    end else begin
      c.qx = $urandom;
      c.qy = $urandom;
      c.qz = $urandom;
      c.qw = $urandom;
    end
    c.tx = rand_shift();
    c.ty = rand_shift();
    c.tz = rand_shift();
    return c;
  endfunction

  task automatic cfg_write(logic [IDX_W-1:0] idx, word_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic program_xform(xf_cfg_t c, bit poke_unused);
    cfg_write(REG_QUAT_X, c.qx);
    cfg_write(REG_QUAT_Y, c.qy);
    cfg_write(REG_QUAT_Z, c.qz);
    cfg_write(REG_QUAT_W, c.qw);
    cfg_write(REG_SHIFT_X, c.tx);
    cfg_write(REG_SHIFT_Y, c.ty);
    cfg_write(REG_SHIFT_Z, c.tz);
    if (poke_unused) cfg_write(REG_UNUSED, word_t'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(point_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pos_x_i        <= p.pos[0];
    pos_y_i        <= p.pos[1];
    pos_z_i        <= p.pos[2];
    radial_speed_i <= p.attr.speed;
    distance_i     <= p.attr.distance;
    bearing_i      <= p.attr.bearing;
    tilt_i         <= p.attr.tilt;
    sensor_id_i    <= p.attr.sensor;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(p);
  endtask

  // stop offering, wait for every pending result, let the matrix pipe settle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (COEF_LAT + 2) @(posedge clk_i);
  endtask

  initial begin : rx_proc
    int      gap;
    bit      held;
    result_t got;
    out_stall_i = 1'b0;
    held        = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        gap  = LONG_HOLD;
        held = 1'b1;
      end else begin
        gap = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.pos[0]        = out_x_o;
      got.pos[1]        = out_y_o;
      got.pos[2]        = out_z_o;
      got.attr.speed    = out_speed_o;
      got.attr.distance = out_distance_o;
      got.attr.bearing  = out_bearing_o;
      got.attr.tilt     = out_tilt_o;
      got.attr.sensor   = out_sensor_o;
      got.clip          = clipped_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int per_phase;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    pos_x_i        = '0;
    pos_y_i        = '0;
    pos_z_i        = '0;
    radial_speed_i = '0;
    distance_i     = '0;
    bearing_i      = '0;
    tilt_i         = '0;
    sensor_id_i    = '0;
    rst_ni         = 1'b0;
    hold_req       = 1'b0;
    idle_on        = 1'b1;
    sb             = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity straight out of reset
    send_point(mk_point('0, '0, '0, '0));
    send_point(mk_point(W_MAX, W_MAX, W_MAX, '1));
    send_point(mk_point(W_MIN, W_MIN, W_MIN, random_attr()));
    send_point(mk_point('1, 32'sd1, 32'sh1234_5678, random_attr()));
    settle();

    // components beyond +1.0 clamp; non-unit matrix saturates
    program_xform('{qx: W_MAX, qy: W_MAX, qz: W_MAX, qw: W_MAX,
                    tx: '0, ty: '0, tz: '0}, 1'b0);
    send_point(mk_point(W_MAX, W_MAX, W_MAX, random_attr()));
    send_point(mk_point(32'sh0001_0000, '0, '0, random_attr()));
    send_point(mk_point(W_MIN, W_MIN, W_MIN, '1));
    send_point(mk_point(32'sd1, 32'sd2, 32'sd3, random_attr()));
    settle();

    // components below -1.0 clamp; translation at the top drives overflow
    program_xform('{qx: W_MIN, qy: W_MIN, qz: W_MIN, qw: W_MIN,
                    tx: W_MAX, ty: W_MAX, tz: W_MAX}, 1'b1);
    send_point(mk_point('0, '0, '0, random_attr()));
    send_point(mk_point(W_MAX, W_MAX, W_MAX, random_attr()));
    send_point(mk_point(32'sh0000_0100, '1, 32'sh0010_0000, random_attr()));
    settle();

    // quarter turn about z, translation at the bottom
    program_xform('{qx: '0, qy: '0, qz: Q_SIN45, qw: Q_SIN45,
                    tx: W_MIN, ty: W_MIN, tz: W_MIN}, 1'b1);
    send_point(mk_point(32'sh0001_0000, '0, '0, random_attr()));
    send_point(mk_point('0, '0, '0, random_attr()));
    send_point(mk_point(W_MIN, W_MIN, W_MIN, random_attr()));
    settle();

    // half turn about x at exactly -1.0
    program_xform('{qx: -Q_UNIT, qy: '0, qz: '0, qw: '0,
                    tx: 32'sh0000_8000, ty: -32'sh0000_8000, tz: 32'sd1}, 1'b0);
    send_point(mk_point(32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000, random_attr()));
    send_point(mk_point(W_MAX, W_MIN, W_MAX, random_attr()));
    send_point(mk_point(W_MIN, W_MAX, W_MIN, random_attr()));
    settle();

    // all-zero quaternion gives the identity matrix
    program_xform('{qx: '0, qy: '0, qz: '0, qw: '0,
                    tx: 32'sd1, ty: '1, tz: W_MAX}, 1'b1);
    send_point(mk_point(W_MAX, W_MIN, 32'sd1, random_attr()));
    send_point(mk_point(W_MIN, W_MAX, '0, random_attr()));
    settle();

    per_phase = N_RANDOM / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      program_xform(random_xform(), ph % 2 == 1);
      idle_on = (ph % 3 != 2);
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < per_phase; i++) begin
        if (ph == 5 && i == per_phase / 2) settle();
        send_point(random_point());
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
